/* rtl/afc_pkg.sv */
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants for the box against frustum cull test
// Plane word layout, box word and the word passed along the cell chain.
// ----------------------------------------------------------------------------
package afc_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int REG_COUNT   = 6;
	localparam int IDX_W       = 3;
	localparam int DATA_W      = 64;
	localparam int COORD_W     = 16;
	localparam int COEF_W      = 16;
	localparam int FRAC_BITS   = 13;
	localparam int PROD_W      = COORD_W + COEF_W;
	localparam int SUM_W       = PROD_W + 2;
	localparam int CELL_STAGES = 2;
	localparam int LATENCY     = CELL_STAGES * PLANE_COUNT;

	typedef logic [DATA_W-1:0] plane_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
	} box_t;

	typedef struct packed {
		logic valid;
		logic cull;
		box_t box;
	} chain_word_t;

endpackage

/* rtl/afc_plane_regs.sv */
// ----------------------------------------------------------------------------
// afc_plane_regs: plane coefficient registers
// Decodes the write port into one 64-bit register per plane; spare slots read
// as the all-zero plane, which never culls.
// ----------------------------------------------------------------------------
module afc_plane_regs
	import afc_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [IDX_W-1:0]             wr_index,
	input  logic [DATA_W-1:0]            wr_data,
	output plane_t [PLANE_COUNT-1:0]     plane
);

	genvar i;
	generate
		for (i = 0; i < PLANE_COUNT; i++) begin : g_slot
			if (i < REG_COUNT) begin : g_reg
				plane_t plane_q;
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						plane_q <= '0;
					end else if (wr_en && (wr_index == IDX_W'(i))) begin
						plane_q <= wr_data;
					end
				end
				assign plane[i] = plane_q;
			end else begin : g_zero
				assign plane[i] = '0;
			end
		end
	endgenerate

endmodule

/* rtl/afc_cell.sv */
// ----------------------------------------------------------------------------
// afc_cell: one plane test in the cull chain
// Stage one forms the six coordinate products, stage two picks the best
// corner per axis, adds the offset and folds the sign into the cull flag.
// ----------------------------------------------------------------------------
module afc_cell
	import afc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  plane_t      plane,
	input  chain_word_t word_in,
	output chain_word_t word_out
);

	logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, coef_d;
	logic signed [PROD_W-1:0] px_lo_s1, px_hi_s1, py_lo_s1, py_hi_s1, pz_lo_s1, pz_hi_s1;
	logic                     valid_s1, cull_s1;
	box_t                     box_s1;
	logic signed [PROD_W-1:0] best_x, best_y, best_z;
	logic signed [SUM_W-1:0]  offset, best_sum;
	logic                     valid_s2, cull_s2;
	box_t                     box_s2;

	assign coef_a = $signed(plane[15:0]);
	assign coef_b = $signed(plane[31:16]);
	assign coef_c = $signed(plane[47:32]);
	assign coef_d = $signed(plane[63:48]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= word_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		cull_s1  <= word_in.cull;
		box_s1   <= word_in.box;
		px_lo_s1 <= PROD_W'(coef_a * word_in.box.min_x);
		px_hi_s1 <= PROD_W'(coef_a * word_in.box.max_x);
		py_lo_s1 <= PROD_W'(coef_b * word_in.box.min_y);
		py_hi_s1 <= PROD_W'(coef_b * word_in.box.max_y);
		pz_lo_s1 <= PROD_W'(coef_c * word_in.box.min_z);
		pz_hi_s1 <= PROD_W'(coef_c * word_in.box.max_z);
	end

	// best corner along each axis is the larger product
	assign best_x = (px_lo_s1 > px_hi_s1) ? px_lo_s1 : px_hi_s1;
	assign best_y = (py_lo_s1 > py_hi_s1) ? py_lo_s1 : py_hi_s1;
	assign best_z = (pz_lo_s1 > pz_hi_s1) ? pz_lo_s1 : pz_hi_s1;

	assign offset   = $signed({{(SUM_W-COEF_W-FRAC_BITS){coef_d[COEF_W-1]}}, coef_d,
		{FRAC_BITS{1'b0}}});
	assign best_sum = SUM_W'(best_x) + SUM_W'(best_y) + SUM_W'(best_z) + offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		box_s2  <= box_s1;
		cull_s2 <= cull_s1 | best_sum[SUM_W-1];
	end

	assign word_out.valid = valid_s2;
	assign word_out.cull  = cull_s2;
	assign word_out.box   = box_s2;

endmodule

/* rtl/aabb_frustum_cull_test_top.sv */
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_top: box against frustum plane visibility test
//
//   channel  | handshake          | words
//   ---------+--------------------+-------------------------------------------
//   box in   | start, busy        | min_x min_y min_z max_x max_y max_z
//   result   | done (strobe)      | visible
//   config   | wr_en              | wr_index, wr_data (one plane per index)
//
// One box is taken every cycle; busy stays low. The result comes out of the
// row of plane cells, each of which holds a product stage and a sum stage.
// Reset clears the pipeline valid flags and sets every plane to zero.
// The receiver cannot stall: done is high for exactly one cycle per box.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test_top
	import afc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] min_x,
	input  logic signed [COORD_W-1:0] min_y,
	input  logic signed [COORD_W-1:0] min_z,
	input  logic signed [COORD_W-1:0] max_x,
	input  logic signed [COORD_W-1:0] max_y,
	input  logic signed [COORD_W-1:0] max_z,
	output logic                      done,
	output logic                      visible,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_index,
	input  logic [DATA_W-1:0]         wr_data
);

	plane_t [PLANE_COUNT-1:0] plane;
	chain_word_t              chain [PLANE_COUNT+1];

	assign busy = 1'b0;

	afc_plane_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.plane    (plane)
	);

	assign chain[0].valid     = start && !busy;
	assign chain[0].cull      = 1'b0;
	assign chain[0].box.min_x = min_x;
	assign chain[0].box.min_y = min_y;
	assign chain[0].box.min_z = min_z;
	assign chain[0].box.max_x = max_x;
	assign chain[0].box.max_y = max_y;
	assign chain[0].box.max_z = max_z;

	genvar i;
	generate
		for (i = 0; i < PLANE_COUNT; i++) begin : g_cell
			afc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.plane    (plane[i]),
				.word_in  (chain[i]),
				.word_out (chain[i+1])
			);
		end
	endgenerate

	assign done    = chain[PLANE_COUNT].valid;
	assign visible = chain[PLANE_COUNT].valid && !chain[PLANE_COUNT].cull;

endmodule

/* rtl/afc_checker.sv */
// ----------------------------------------------------------------------------
// afc_checker: port-level checks for the cull test
// Watches busy, start, done and visible against the chain latency.
// ----------------------------------------------------------------------------
module afc_checker
	import afc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic visible
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised on a block that takes a box every cycle");

	a_done_has_box: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a box taken at the chain latency");

	a_box_gets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("box taken but no result after the chain latency");

	a_visible_qualified: assert property (@(posedge clk) disable iff (!arst_n)
		visible |-> done)
		else $error("visible high outside a result word");

endmodule

bind aabb_frustum_cull_test_top afc_checker u_afc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.visible (visible)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: box against frustum plane cull test
// Streams boxes through the cull block under several plane settings and
// checks every visible flag against an in-bench plane evaluation. Settings
// are changed only with the pipeline drained; the sender idles at random.
// ----------------------------------------------------------------------------
module testbench;
	import afc_pkg::*;

	localparam logic [IDX_W-1:0] IDX_TOP    = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_BOTTOM = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_LEFT   = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_RIGHT  = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_NEAR   = IDX_W'(4);
	localparam logic [IDX_W-1:0] IDX_FAR    = IDX_W'(5);
	localparam logic [IDX_W-1:0] IDX_SPARE0 = IDX_W'(6);
	localparam logic [IDX_W-1:0] IDX_SPARE1 = IDX_W'(7);

	localparam int ONE_Q13       = 1 << FRAC_BITS;
	localparam int IDLE_PCT      = 12;
	localparam int QUIET_FIRST   = 500;
	localparam int QUIET_LAST    = 800;
	localparam int RANDOM_PHASES = 10;
	localparam int BOXES_PER_PHASE = 115;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	box_t              box_drv = '0;
	logic              done;
	logic              visible;
	logic              wr_en = 1'b0;
	logic [IDX_W-1:0]  wr_index = '0;
	logic [DATA_W-1:0] wr_data = '0;

	plane_t plane_cfg [REG_COUNT];
	box_t   box_q [$];
	logic   visible_q [$];
	logic   box_taken = 1'b0;
	int     boxes_sent = 0;
	int     fail_count = 0;

	aabb_frustum_cull_test_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.min_x    (box_drv.min_x),
		.min_y    (box_drv.min_y),
		.min_z    (box_drv.min_z),
		.max_x    (box_drv.max_x),
		.max_y    (box_drv.max_y),
		.max_z    (box_drv.max_z),
		.done     (done),
		.visible  (visible),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	// Larger of the two products per axis picks the corner furthest in front.
	function automatic logic box_visible(box_t b);
		longint lo [3];
		longint hi [3];
		longint coef, p, q, best;
		logic   vis;
		lo[0] = longint'($signed(b.min_x));
		lo[1] = longint'($signed(b.min_y));
		lo[2] = longint'($signed(b.min_z));
		hi[0] = longint'($signed(b.max_x));
		hi[1] = longint'($signed(b.max_y));
		hi[2] = longint'($signed(b.max_z));
		vis = 1'b1;
		for (int i = 0; i < PLANE_COUNT; i++) begin
			best = longint'($signed(plane_cfg[i][63:48])) <<< FRAC_BITS;
			for (int k = 0; k < 3; k++) begin
				coef = longint'($signed(plane_cfg[i][16*k +: 16]));
				p = coef * lo[k];
				q = coef * hi[k];
				best += (p > q) ? p : q;
			end
			if (best < 0)
				vis = 1'b0;
		end
		return vis;
	endfunction

	function automatic plane_t plane_word(int a, int b, int c, int d);
		logic [15:0] a16, b16, c16, d16;
		a16 = a[15:0];
		b16 = b[15:0];
		c16 = c[15:0];
		d16 = d[15:0];
		return {d16, c16, b16, a16};
	endfunction

	function automatic box_t box_of(int nx, int ny, int nz, int xx, int xy, int xz);
		box_t b;
		b.min_x = nx[15:0];
		b.min_y = ny[15:0];
		b.min_z = nz[15:0];
		b.max_x = xx[15:0];
		b.max_y = xy[15:0];
		b.max_z = xz[15:0];
		return b;
	endfunction

	function automatic int pick_extreme();
		case ($urandom_range(4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	function automatic plane_t rand_plane();
		int kind;
		kind = $urandom_range(9);
		if (kind < 2)
			return '0;
		if (kind < 7)
			return plane_word($urandom_range(2 * ONE_Q13) - ONE_Q13,
				$urandom_range(2 * ONE_Q13) - ONE_Q13,
				$urandom_range(2 * ONE_Q13) - ONE_Q13,
				$urandom_range(8192) - 4096);
		if (kind < 9)
			return {$urandom, $urandom};
		return plane_word(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
	endfunction

	function automatic box_t rand_box();
		int   kind, cx, cy, cz, hx, hy, hz, span;
		box_t b;
		kind = $urandom_range(9);
		if (kind < 6) begin
			span = ($urandom_range(3) == 0) ? 16384 : 4096;
			cx = $urandom_range(2 * span) - span;
			cy = $urandom_range(2 * span) - span;
			cz = $urandom_range(2 * span) - span;
			hx = $urandom_range($urandom_range(512));
			hy = $urandom_range($urandom_range(512));
			hz = $urandom_range($urandom_range(512));
			b = box_of(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
			// occasionally hand the corners over the wrong way round
			if ($urandom_range(9) == 0)
				b = box_of(cx + hx, cy + hy, cz + hz, cx - hx, cy - hy, cz - hz);
		end else if (kind < 8) begin
			b = box_t'({$urandom, $urandom, $urandom});
		end else begin
			b = box_of(pick_extreme(), pick_extreme(), pick_extreme(),
				pick_extreme(), pick_extreme(), pick_extreme());
		end
		return b;
	endfunction

	task automatic put_plane(logic [IDX_W-1:0] idx, plane_t word);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= word;
		if (idx < REG_COUNT)
			plane_cfg[idx] = word;
	endtask

	task automatic end_writes();
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Hold until every queued box has gone in and every flag has come back.
	// Look just after the falling edge so the sender has settled this cycle.
	task automatic drain();
		@(negedge clk);
		#1;
		while (box_q.size() != 0 || start || visible_q.size() != 0) begin
			@(negedge clk);
			#1;
		end
	endtask

	// Sender: present the next box once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!start || box_taken)) begin
			if (box_q.size() != 0 && (($urandom_range(99) >= IDLE_PCT) ||
					(boxes_sent >= QUIET_FIRST && boxes_sent < QUIET_LAST))) begin
				box_drv <= box_q.pop_front();
				start <= 1'b1;
				boxes_sent <= boxes_sent + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (visible_q.size() == 0) begin
					$error("visible: word with no expectation waiting, got %0b", visible);
					fail_count++;
				end else begin
					logic want;
					want = visible_q.pop_front();
					if (visible !== want) begin
						$error("visible: expected %0b, got %0b", want, visible);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				visible_q.push_back(box_visible(box_drv));
		end
		box_taken <= arst_n && start && !busy;
	end

	initial begin
		for (int i = 0; i < REG_COUNT; i++)
			plane_cfg[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Planes as left by reset: all zero, nothing culls.
		box_q.push_back(box_of(-32768, -32768, -32768, -32768, -32768, -32768));
		box_q.push_back(box_of(32767, 32767, 32767, 32767, 32767, 32767));
		box_q.push_back(box_of(32767, -32768, 32767, -32768, 32767, -32768));
		drain();

		// A plain frustum: |x| and |y| up to 100, z from 10 to 1000.
		put_plane(IDX_TOP,    plane_word(0, -ONE_Q13, 0, 100));
		put_plane(IDX_BOTTOM, plane_word(0, ONE_Q13, 0, 100));
		put_plane(IDX_LEFT,   plane_word(ONE_Q13, 0, 0, 100));
		put_plane(IDX_RIGHT,  plane_word(-ONE_Q13, 0, 0, 100));
		put_plane(IDX_NEAR,   plane_word(0, 0, ONE_Q13, -10));
		put_plane(IDX_FAR,    plane_word(0, 0, -ONE_Q13, 1000));
		// indexes past the last plane must be dropped
		put_plane(IDX_SPARE0, '1);
		put_plane(IDX_SPARE1, plane_word(0, 0, 0, -1));
		end_writes();
		box_q.push_back(box_of(-10, -10, 20, 10, 10, 30));
		box_q.push_back(box_of(-10, -10, 0, 10, 10, 9));
		box_q.push_back(box_of(-10, -10, 0, 10, 10, 10));
		box_q.push_back(box_of(-10, -10, 1001, 10, 10, 2000));
		box_q.push_back(box_of(-200, -10, 20, -50, 10, 30));
		box_q.push_back(box_of(-300, -10, 20, -101, 10, 30));
		box_q.push_back(box_of(10, 10, 30, -10, -10, 20));
		box_q.push_back(box_of(10, 10, 9, -10, -10, 0));
		box_q.push_back(box_of(-32768, -32768, -32768, 32767, 32767, 32767));
		box_q.push_back(box_of(0, 0, 0, 0, 0, 0));
		box_q.push_back(box_of(32767, 32767, 32767, 32767, 32767, 32767));
		drain();

		// Largest magnitudes in every field.
		put_plane(IDX_TOP,    plane_word(-32768, -32768, -32768, -32768));
		put_plane(IDX_BOTTOM, plane_word(32767, 32767, 32767, 32767));
		put_plane(IDX_LEFT,   '0);
		put_plane(IDX_RIGHT,  '0);
		put_plane(IDX_NEAR,   '0);
		put_plane(IDX_FAR,    '0);
		end_writes();
		box_q.push_back(box_of(32767, 32767, 32767, 32767, 32767, 32767));
		box_q.push_back(box_of(-32768, -32768, -32768, -32768, -32768, -32768));
		box_q.push_back(box_of(-32768, -32768, -32768, 32767, 32767, 32767));
		box_q.push_back(box_of(0, 0, 0, 0, 0, 0));
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			for (int i = 0; i < REG_COUNT; i++)
				put_plane(i[IDX_W-1:0], rand_plane());
			if ($urandom_range(2) == 0)
				put_plane($urandom_range(1) ? IDX_SPARE0 : IDX_SPARE1, {$urandom, $urandom});
			end_writes();
			for (int i = 0; i < BOXES_PER_PHASE; i++)
				box_q.push_back(rand_box());
			drain();
		end

		// catch any stray strobe behind the last word
		repeat (LATENCY + 4) @(negedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule
